@@ rtl/core/slt_pkg.sv @@
package slt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int ACTION_W      = 2;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;
   localparam int RSP_FIELDS_W  = STATUS_W + 1 + ENTRY_COUNT_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // field positions in the response word
   localparam int FOUND_BIT = STATUS_W;
   localparam int COUNT_LSB = STATUS_W + 1;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_SHIFT_UP = 6'b000100,
      ST_INS_WR   = 6'b001000,
      ST_SHIFT_DN = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

endpackage

@@ rtl/core/sorted_list_table.sv @@
// Sorted value table: up to TABLE_DEPTH signed 32-bit values kept in
// ascending order, duplicates allowed.
// Request channel (req_): tuser carries the action (insert, search, delete),
// tdata the value; req_tready is high only while the sequencer is idle.
// Response channel (rsp_): one word per request with status, found flag and
// the entry count after the request.
// Steps from request acceptance to response valid, with count entries
// stored and pos the first entry not smaller than the value:
//   scan        entries up to pos compared (one entry compared per cycle)
//   insert      + (count - pos) entries shifted up + 1 write (none if full)
//   delete      + (count - pos - 1) entries shifted down (none if not found)
//   completion  + response word loaded into the output register
// The pace is set by the one table memory moving one entry per cycle and
// the one shared comparator; a new request is taken only once the
// sequencer is back in idle.
// While rsp_tready is low the word waits in the output register; the next
// request is still taken and then waits in its completion step.
// Reset empties the table (count to zero) and drops any pending response.
module sorted_list_table (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slt_pkg::VALUE_W-1:0]         req_tdata,  // [31:0] value
   input  logic [slt_pkg::ACTION_W-1:0]        req_tuser,  // [1:0] action
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slt_pkg::RSP_TDATA_W-1:0]     rsp_tdata   // [1:0] status,
                                                           // [2] found,
                                                           // [7:3] entry_count
);
   import slt_pkg::*;

   // table memory
   logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   // sequencer and working registers
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [ADDR_W-1:0]         ptr_ff, ptr_in;
   logic [ADDR_W-1:0]         pos_ff, pos_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [ACTION_W-1:0]       action_ff, action_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // shared compare unit
   logic cmp_lt;
   logic cmp_eq;
   logic scan_at_end;
   logic scan_stop;
   logic present;

   assign cmp_lt      = rd_data_ff < value_ff;
   assign cmp_eq      = rd_data_ff == value_ff;
   assign scan_at_end = idx_ff == count_ff;
   assign scan_stop   = scan_at_end || !cmp_lt;
   assign present     = !scan_at_end && cmp_eq;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      action_in    = action_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = value_ff;

      case (state_ff)
         ST_IDLE: begin
            // first entry is read while the request is taken
            if (req_tvalid) begin
               value_in  = req_tdata;
               action_in = req_tuser;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (!scan_stop) begin
               idx_in  = idx_ff + CNT_W'(1);
               rd_addr = ADDR_W'(idx_ff + CNT_W'(1));
            end else begin
               pos_in    = ADDR_W'(idx_ff);
               status_in = STAT_OK;
               found_in  = 1'b0;
               state_in  = ST_DONE;
               case (action_ff)
                  ACT_INSERT: begin
                     found_in = present;
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        status_in = STAT_FULL;
                     end else if (count_ff != idx_ff) begin
                        // move the tail up, starting from the last entry
                        ptr_in   = ADDR_W'(count_ff - CNT_W'(1));
                        rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = ST_SHIFT_UP;
                     end else begin
                        state_in = ST_INS_WR;
                     end
                  end
                  ACT_SEARCH: begin
                     found_in = present;
                  end
                  ACT_DELETE: begin
                     if (present) begin
                        found_in = 1'b1;
                        if (idx_ff + CNT_W'(1) != count_ff) begin
                           // pull the tail down over the removed entry
                           ptr_in   = ADDR_W'(idx_ff + CNT_W'(1));
                           rd_addr  = ADDR_W'(idx_ff + CNT_W'(1));
                           state_in = ST_SHIFT_DN;
                        end else begin
                           count_in = count_ff - CNT_W'(1);
                        end
                     end else begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end

         ST_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + ADDR_W'(1);
            wr_data = rd_data_ff;
            if (ptr_ff == pos_ff) begin
               state_in = ST_INS_WR;
            end else begin
               ptr_in  = ptr_ff - ADDR_W'(1);
               rd_addr = ptr_ff - ADDR_W'(1);
            end
         end

         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = value_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end

         ST_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - ADDR_W'(1);
            wr_data = rd_data_ff;
            if (CNT_W'(ptr_ff) + CNT_W'(1) == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               ptr_in  = ptr_ff + ADDR_W'(1);
               rd_addr = ptr_ff + ADDR_W'(1);
            end
         end

         ST_DONE: begin
            // load the response word once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({ENTRY_COUNT_W'(count_ff), found_ff, status_ff});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      action_ff   <= action_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

endmodule

@@ rtl/core/slt_checker.sv @@
module slt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [slt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import slt_pkg::*;

   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_found;
   logic [ENTRY_COUNT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_found  = rsp_tdata[FOUND_BIT];
   assign rsp_count  = rsp_tdata[COUNT_LSB +: ENTRY_COUNT_W];

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // a taken request blocks a back-to-back request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // entry count never exceeds the table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= ENTRY_COUNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a full rejection reports a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STAT_FULL |-> rsp_count == ENTRY_COUNT_W'(TABLE_DEPTH))
      else $error("full status with table not full");

   // a failed delete never reports the value as found
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STAT_NOT_FOUND |-> !rsp_found)
      else $error("not found status with found flag set");

endmodule

bind sorted_list_table slt_checker u_slt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
